>>> design/fogf_pkg.sv
package fogf_pkg;

  // Storage geometry
  localparam int FINE_COLS_MAX   = 128;
  localparam int FINE_ROWS_MAX   = 128;
  localparam int COARSE_COLS_MAX = 16;
  localparam int COARSE_ROWS_MAX = 16;

  localparam int FC_W = (FINE_COLS_MAX > 1) ? $clog2(FINE_COLS_MAX) : 1;
  localparam int FR_W = (FINE_ROWS_MAX > 1) ? $clog2(FINE_ROWS_MAX) : 1;
  localparam int CC_W = (COARSE_COLS_MAX > 1) ? $clog2(COARSE_COLS_MAX) : 1;
  localparam int CR_W = (COARSE_ROWS_MAX > 1) ? $clog2(COARSE_ROWS_MAX) : 1;

  // Screening constants
  localparam int EDGE_PX    = 10;
  localparam int MASK_LIMIT = 127;
  localparam int COUNT_MAX  = 255;
  localparam int KEPT_MAX   = 4095;
  localparam int NEED_CAP   = 20;

  // Shared divider geometry: 16-bit coordinate times 5-bit grid count
  localparam int DIVD_W = 21;
  localparam int DIVS_W = 16;
  localparam int DCNT_W = $clog2(DIVD_W + 1);

  // Request codes
  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_TRACK = 2'd1;
  localparam logic [1:0] REQ_NEW   = 2'd2;

  // Reason codes
  localparam logic [2:0] RSN_OK     = 3'd0;
  localparam logic [2:0] RSN_BORDER = 3'd1;
  localparam logic [2:0] RSN_FINE   = 3'd2;
  localparam logic [2:0] RSN_COARSE = 3'd3;
  localparam logic [2:0] RSN_CLOSE  = 3'd4;
  localparam logic [2:0] RSN_MASKED = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_IMG_W   = 3'd0;
  localparam logic [2:0] CFG_IMG_H   = 3'd1;
  localparam logic [2:0] CFG_MIN_D   = 3'd2;
  localparam logic [2:0] CFG_GRID_C  = 3'd3;
  localparam logic [2:0] CFG_GRID_R  = 3'd4;
  localparam logic [2:0] CFG_TARGET  = 3'd5;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> design/fogf_div.sv
module fogf_div
  import fogf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;

  // One restoring step: bring down the next dividend bit
  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIVD_W);
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        quo_r <= {quo_r[DIVD_W-2:0], ge};
        rem_r <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> design/feature_occupancy_grid_filter.sv
// Keypoint thinning by a minimum-distance occupancy bitmap and coarse cell counters.
// One transaction is in work at a time. A new candidate, or a tracked point that falls
// outside the fine grid, passes through the fine divide, the fine check, the memory
// read and the decision before its result; any other tracked point also passes a
// coarse divide after the fine check. Two 21-step shift-subtract dividers (x and y)
// find the fine cell, and then, for tracked points inside the fine grid, the coarse cell.
// A border reject or an unused request code goes straight to the result. The next
// transaction can be taken once a result is loaded. After reset and after every
// frame-start transaction the block sweeps both memories (one fine row per cycle, a
// coarse row with each of the first 16) and takes no transaction meanwhile; the
// frame-start result follows the sweep. Configuration writes are taken at any time.
module feature_occupancy_grid_filter
  import fogf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [7:0]  in_mask_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [2:0]  out_reason,
  output logic [7:0]  out_cell_count,
  output logic [11:0] out_kept_count,
  output logic [31:0] out_new_id,
  output logic        out_detection_needed
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FDIV  = 3'd2;
  localparam logic [2:0] S_FCHK  = 3'd3;
  localparam logic [2:0] S_CDIV  = 3'd4;
  localparam logic [2:0] S_MEM   = 3'd5;
  localparam logic [2:0] S_DEC   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam int CROW_W = COARSE_COLS_MAX * 8;

  // Configuration registers
  logic [11:0] img_w_r, img_h_r, target_r;
  logic [7:0]  min_dist_r;
  logic [4:0]  grid_cols_r, grid_rows_r;

  // Control and working registers
  logic [2:0]        state_r;
  logic [1:0]        req_r;
  logic [15:0]       px_r, py_r;
  logic [7:0]        mask_r;
  logic [11:0]       cx_r, cy_r;
  logic [DIVD_W-1:0] gx_r, gy_r;
  logic              fine_ok_r;
  logic [FR_W-1:0]   sweep_r;
  logic              clr_res_r;
  logic [11:0]       kept_r;
  logic [31:0]       id_r;
  logic              res_acc_r;
  logic [2:0]        res_rsn_r;
  logic [7:0]        res_cell_r;
  logic [31:0]       res_id_r;
  logic              out_valid_r;

  // Memories and their read registers
  logic [FINE_COLS_MAX-1:0] fine_mem [FINE_ROWS_MAX];
  logic [CROW_W-1:0]        coarse_mem [COARSE_ROWS_MAX];
  logic [FINE_COLS_MAX-1:0] fine_row_r;
  logic [CROW_W-1:0]        coarse_row_r;

  logic                     fine_we, coarse_we;
  logic [FR_W-1:0]          fine_wa;
  logic [CR_W-1:0]          coarse_wa;
  logic [FINE_COLS_MAX-1:0] fine_wd;
  logic [CROW_W-1:0]        coarse_wd;

  div_req_t xreq, yreq;
  div_rsp_t xrsp, yrsp;

  logic        in_acc;
  logic [11:0] x_int, y_int;
  logic        border;
  logic [7:0]  md_eff;
  logic [4:0]  gc, gr;
  logic [20:0] prod_x, prod_y;
  logic        fine_ok;
  logic        coarse_ok;
  logic        fine_taken;
  logic [7:0]  cnt_old, cnt_new;
  logic [CC_W-1:0] gx_idx;
  logic        dec_keep;
  logic [2:0]  dec_rsn;
  logic        dn;

  assign in_stall = state_r != S_IDLE;
  assign in_acc   = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r     <= 12'd752;
      img_h_r     <= 12'd480;
      min_dist_r  <= 8'd10;
      grid_cols_r <= 5'd5;
      grid_rows_r <= 5'd5;
      target_r    <= 12'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMG_W:  img_w_r     <= cfg_wdata;
        CFG_IMG_H:  img_h_r     <= cfg_wdata;
        CFG_MIN_D:  min_dist_r  <= cfg_wdata[7:0];
        CFG_GRID_C: grid_cols_r <= cfg_wdata[4:0];
        CFG_GRID_R: grid_rows_r <= cfg_wdata[4:0];
        CFG_TARGET: target_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Border screen on the incoming transaction
  assign x_int  = in_pos_x[15:4];
  assign y_int  = in_pos_y[15:4];
  assign border = (x_int < 12'(EDGE_PX)) || ({1'b0, x_int} + 13'(EDGE_PX) >= {1'b0, img_w_r}) ||
                  (y_int < 12'(EDGE_PX)) || ({1'b0, y_int} + 13'(EDGE_PX) >= {1'b0, img_h_r});

  assign md_eff = (min_dist_r == 8'd0) ? 8'd1 : min_dist_r;
  assign gc = (32'(grid_cols_r) > COARSE_COLS_MAX) ? 5'(COARSE_COLS_MAX) : grid_cols_r;
  assign gr = (32'(grid_rows_r) > COARSE_ROWS_MAX) ? 5'(COARSE_ROWS_MAX) : grid_rows_r;

  // Fine range: cell inside floor(size / min_dist), clipped to storage
  assign prod_x  = (21'(cx_r) + 21'd1) * 21'(md_eff);
  assign prod_y  = (21'(cy_r) + 21'd1) * 21'(md_eff);
  assign fine_ok = (32'(cx_r) < FINE_COLS_MAX) && (prod_x <= 21'(img_w_r)) &&
                   (32'(cy_r) < FINE_ROWS_MAX) && (prod_y <= 21'(img_h_r));

  // Divider requests: fine cell from idle, coarse cell after the fine check
  always_comb begin
    xreq = '0;
    yreq = '0;
    if (state_r == S_IDLE) begin
      xreq.start    = in_acc && (in_req_type == REQ_NEW ||
                                 (in_req_type == REQ_TRACK && !border));
      xreq.dividend = DIVD_W'(x_int);
      xreq.divisor  = DIVS_W'(md_eff);
      yreq.start    = xreq.start;
      yreq.dividend = DIVD_W'(y_int);
      yreq.divisor  = DIVS_W'(md_eff);
    end else begin
      xreq.start    = (state_r == S_FCHK) && (req_r == REQ_TRACK) && fine_ok;
      xreq.dividend = DIVD_W'(px_r) * DIVD_W'(gc);
      xreq.divisor  = DIVS_W'({img_w_r, 4'b0000});
      yreq.start    = xreq.start;
      yreq.dividend = DIVD_W'(py_r) * DIVD_W'(gr);
      yreq.divisor  = DIVS_W'({img_h_r, 4'b0000});
    end
  end

  fogf_div u_xdiv (.clk(clk), .rst_n(rst_n), .req(xreq), .rsp(xrsp));
  fogf_div u_ydiv (.clk(clk), .rst_n(rst_n), .req(yreq), .rsp(yrsp));

  // Decision on the read-back rows
  assign coarse_ok  = (gc != 5'd0) && (gr != 5'd0) &&
                      (gx_r < DIVD_W'(gc)) && (gy_r < DIVD_W'(gr));
  assign gx_idx     = gx_r[CC_W-1:0];
  assign fine_taken = fine_row_r[cx_r[FC_W-1:0]];
  assign cnt_old    = coarse_row_r[{gx_idx, 3'b000} +: 8];
  assign cnt_new    = (cnt_old == 8'(COUNT_MAX)) ? cnt_old : cnt_old + 8'd1;

  always_comb begin
    dec_keep = 1'b0;
    dec_rsn  = RSN_OK;
    if (req_r == REQ_TRACK) begin
      if (!fine_ok_r)                         dec_rsn = RSN_FINE;
      else if (!coarse_ok)                    dec_rsn = RSN_COARSE;
      else if (fine_taken)                    dec_rsn = RSN_CLOSE;
      else if (mask_r > 8'(MASK_LIMIT))       dec_rsn = RSN_MASKED;
      else                                    dec_keep = 1'b1;
    end else begin
      if (!fine_ok_r)                         dec_rsn = RSN_FINE;
      else if (fine_taken)                    dec_rsn = RSN_CLOSE;
      else                                    dec_keep = 1'b1;
    end
  end

  // Memory write ports: clearing sweep or read-modify-write
  always_comb begin
    fine_we   = 1'b0;
    fine_wa   = sweep_r;
    fine_wd   = '0;
    coarse_we = 1'b0;
    coarse_wa = sweep_r[CR_W-1:0];
    coarse_wd = '0;
    if (state_r == S_CLEAR) begin
      fine_we   = 1'b1;
      coarse_we = 32'(sweep_r) < COARSE_ROWS_MAX;
    end else if (state_r == S_DEC && dec_keep) begin
      fine_we = 1'b1;
      fine_wa = cy_r[FR_W-1:0];
      fine_wd = fine_row_r | (FINE_COLS_MAX'(1) << cx_r[FC_W-1:0]);
      if (req_r == REQ_TRACK) begin
        coarse_we = 1'b1;
        coarse_wa = gy_r[CR_W-1:0];
        for (int i = 0; i < COARSE_COLS_MAX; i++) begin
          coarse_wd[i*8 +: 8] = (CC_W'(i) == gx_idx) ? cnt_new : coarse_row_r[i*8 +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fine_we) fine_mem[fine_wa] <= fine_wd;
    fine_row_r <= fine_mem[cy_r[FR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (coarse_we) coarse_mem[coarse_wa] <= coarse_wd;
    coarse_row_r <= coarse_mem[gy_r[CR_W-1:0]];
  end

  // Detection demand from the kept count
  assign dn = (target_r >= kept_r) &&
              ((target_r - kept_r) >= ((target_r[11:1] < 11'(NEED_CAP)) ?
                                       {1'b0, target_r[11:1]} : 12'(NEED_CAP)));

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      clr_res_r   <= 1'b0;
      kept_r      <= '0;
      id_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise the result on load, drop it once taken
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          sweep_r <= sweep_r + 1'b1;
          if (32'(sweep_r) == FINE_ROWS_MAX - 1) begin
            state_r <= clr_res_r ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            req_r      <= in_req_type;
            px_r       <= in_pos_x;
            py_r       <= in_pos_y;
            mask_r     <= in_mask_value;
            res_acc_r  <= 1'b0;
            res_rsn_r  <= RSN_OK;
            res_cell_r <= '0;
            res_id_r   <= '0;
            case (in_req_type)
              REQ_FRAME: begin
                kept_r    <= '0;
                sweep_r   <= '0;
                clr_res_r <= 1'b1;
                state_r   <= S_CLEAR;
              end
              REQ_TRACK: begin
                if (border) begin
                  res_rsn_r <= RSN_BORDER;
                  state_r   <= S_OUT;
                end else begin
                  state_r <= S_FDIV;
                end
              end
              REQ_NEW: state_r <= S_FDIV;
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_FDIV: begin
          if (xrsp.done) begin
            cx_r    <= xrsp.quotient[11:0];
            cy_r    <= yrsp.quotient[11:0];
            state_r <= S_FCHK;
          end
        end
        S_FCHK: begin
          fine_ok_r <= fine_ok;
          state_r   <= xreq.start ? S_CDIV : S_MEM;
        end
        S_CDIV: begin
          if (xrsp.done) begin
            gx_r    <= xrsp.quotient;
            gy_r    <= yrsp.quotient;
            state_r <= S_MEM;
          end
        end
        S_MEM: state_r <= S_DEC;
        S_DEC: begin
          res_rsn_r <= dec_rsn;
          res_acc_r <= dec_keep;
          if (dec_keep) begin
            if (req_r == REQ_TRACK) begin
              res_cell_r <= cnt_new;
              if (kept_r != 12'(KEPT_MAX)) kept_r <= kept_r + 12'd1;
            end else begin
              id_r     <= id_r + 32'd1;
              res_id_r <= id_r + 32'd1;
            end
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_accepted         <= res_acc_r;
            out_reason           <= res_rsn_r;
            out_cell_count       <= res_cell_r;
            out_kept_count       <= kept_r;
            out_new_id           <= res_id_r;
            out_detection_needed <= dn;
            clr_res_r            <= 1'b0;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/fogf_checker.sv
module fogf_checker
  import fogf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_accepted,
  input logic [2:0]  out_reason,
  input logic [7:0]  out_cell_count,
  input logic [11:0] out_kept_count,
  input logic [31:0] out_new_id,
  input logic        out_detection_needed
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reason) &&
      $stable(out_accepted) && $stable(out_kept_count) && $stable(out_new_id) &&
      $stable(out_cell_count) && $stable(out_detection_needed))
    else $error("stalled result changed");

  // One transaction in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // A kept point carries no rejection reason
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_reason == RSN_OK)
    else $error("kept point with reason");

  // A rejected point gets neither id nor count
  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_new_id == 32'd0 && out_cell_count == 8'd0)
    else $error("rejected point with id or count");

  // Tracked and new results never mix
  a_mix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cell_count != 8'd0 |-> out_new_id == 32'd0)
    else $error("count and id together");

endmodule

bind feature_occupancy_grid_filter fogf_checker u_fogf_checker (.*);
